// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the film accumulator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/wfa_pkg.sv =====
// Package for the weighted film accumulator: payload structs, sizes, codes.
// Depends on nothing.
package wfa_pkg;

    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int MaxSplat  = 8;
    localparam int Pixels    = MaxWidth * MaxHeight;
    localparam int AddrBits  = $clog2(Pixels);
    localparam int DimBits   = 9;
    localparam int SumBits   = 48;
    localparam int WsumBits  = 32;
    localparam int QuotBits  = 17;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic               command;
        logic [7:0]         pos_x;
        logic [7:0]         pos_y;
        logic [3:0]         splat_size;
        logic [15:0]        color_red;
        logic [15:0]        color_green;
        logic [15:0]        color_blue;
        logic signed [15:0] sample_weight;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_red;
        logic [15:0] pixel_green;
        logic [15:0] pixel_blue;
        logic        out_of_range;
    } out_item_t;

endpackage

// ===== hw/rtl/weighted_film_accumulator.sv =====
// Weighted film accumulator, top level: control sequencer and pixel memories.
// Depends on wfa_pkg, wfa_divider and assert_macros.svh.
//
// A 256x256 film that holds per pixel three Q24.24 colour sums, a Q20.12
// weight sum and a Q0.16 display colour, each in a synchronous memory with a
// registered read. After reset the block runs a clearing pass over all 65536
// entries (one entry per cycle) during which s_ready stays low; config writes
// are taken throughout. A read beat passes ST_RD_WAIT and ST_RD_OUT, where its
// result is registered once the output register is free. An accumulate beat
// walks its splat one pixel at a time: each pixel inside the active area takes
// a memory pass (select, read, multiply, update, write back) and, for a
// positive weight sum, three 52-step divisions on the shared serial divider;
// skipped pixels go straight from ST_PIX to ST_WAIT. A new beat is taken only
// while the block is idle and the output register is empty or drains at the
// same edge, so a read result held back by m_ready stalls the input.
module weighted_film_accumulator (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  wfa_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wfa_pkg::out_item_t    m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [8:0]            cfg_data
);
`include "assert_macros.svh"

    localparam int AB = wfa_pkg::AddrBits;
    localparam int SB = wfa_pkg::SumBits;
    localparam int WB = wfa_pkg::WsumBits;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_RD_OUT, ST_PIX, ST_LOAD,
        ST_MUL, ST_UPD, ST_DIV_R, ST_DIV_G, ST_DIV_B, ST_WAIT
    } state_t;

    // memories
    logic [SB-1:0] mem_sr [wfa_pkg::Pixels];
    logic [SB-1:0] mem_sg [wfa_pkg::Pixels];
    logic [SB-1:0] mem_sb [wfa_pkg::Pixels];
    logic [WB-1:0] mem_w  [wfa_pkg::Pixels];
    logic [47:0]   mem_sh [wfa_pkg::Pixels];

    logic [AB-1:0] rd_addr, wr_addr;
    logic          wr_acc, wr_sh;
    logic [SB-1:0] wd_sr, wd_sg, wd_sb, q_sr_reg, q_sg_reg, q_sb_reg;
    logic [WB-1:0] wd_w, q_w_reg;
    logic [47:0]   wd_sh, q_sh_reg;

    always_ff @(posedge aclk) begin
        if (wr_acc) begin
            mem_sr[wr_addr] <= wd_sr;
            mem_sg[wr_addr] <= wd_sg;
            mem_sb[wr_addr] <= wd_sb;
            mem_w[wr_addr]  <= wd_w;
        end
        if (wr_sh) begin
            mem_sh[wr_addr] <= wd_sh;
        end
        q_sr_reg <= mem_sr[rd_addr];
        q_sg_reg <= mem_sg[rd_addr];
        q_sb_reg <= mem_sb[rd_addr];
        q_w_reg  <= mem_w[rd_addr];
        q_sh_reg <= mem_sh[rd_addr];
    end

    state_t            state_reg;
    logic [8:0]        width_reg, height_reg;
    wfa_pkg::in_item_t item_reg;
    logic [3:0]        i_reg, j_reg, size_reg;
    logic [AB-1:0]     addr_reg, clr_reg;
    logic signed [SB-1:0] pr_reg, pg_reg, pb_reg, nr_reg, ng_reg, nb_reg;
    logic signed [WB-1:0] nw_reg;
    logic [47:0]       sh_reg;
    logic              pend_reg, oor_reg;
    wfa_pkg::out_item_t out_reg;
    logic              out_valid_reg;

    // effective dimensions
    logic [8:0] eff_w, eff_h;
    assign eff_w = (width_reg  > 9'(wfa_pkg::MaxWidth))  ? 9'(wfa_pkg::MaxWidth)  : width_reg;
    assign eff_h = (height_reg > 9'(wfa_pkg::MaxHeight)) ? 9'(wfa_pkg::MaxHeight) : height_reg;

    // current splat pixel
    logic [8:0]  cur_x, cur_y;
    logic        cur_in;
    logic [17:0] cur_lin;
    assign cur_x   = 9'(item_reg.pos_x) + 9'(i_reg);
    assign cur_y   = 9'(item_reg.pos_y) + 9'(j_reg);
    assign cur_in  = (cur_x < eff_w) && (cur_y < eff_h);
    assign cur_lin = 18'(cur_y) * 18'(eff_w) + 18'(cur_x);

    logic [17:0] s_lin;
    logic        s_in;
    assign s_in  = (9'(s_data.pos_x) < eff_w) && (9'(s_data.pos_y) < eff_h);
    assign s_lin = 18'(s_data.pos_y) * 18'(eff_w) + 18'(s_data.pos_x);

    // colour times weight, 17x16 signed
    logic signed [32:0] mul_r, mul_g, mul_b;
    assign mul_r = $signed({1'b0, item_reg.color_red})   * $signed(item_reg.sample_weight);
    assign mul_g = $signed({1'b0, item_reg.color_green}) * $signed(item_reg.sample_weight);
    assign mul_b = $signed({1'b0, item_reg.color_blue})  * $signed(item_reg.sample_weight);

    // saturating adds
    function automatic logic signed [SB-1:0] sat48(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b);
        logic signed [SB:0] s;
        s = {a[SB-1], a} + {b[SB-1], b};
        if (s[SB] != s[SB-1]) begin
            sat48 = s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
            sat48 = s[SB-1:0];
        end
    endfunction

    logic signed [WB:0] wadd;
    logic signed [WB-1:0] wsat;
    always_comb begin
        wadd = {q_w_reg[WB-1], q_w_reg} + (WB+1)'($signed(item_reg.sample_weight));
        if (wadd[WB] != wadd[WB-1]) begin
            wsat = wadd[WB] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
        end else begin
            wsat = wadd[WB-1:0];
        end
    end

    // divider
    logic              div_start, div_done;
    logic signed [SB-1:0] div_sum;
    logic [15:0]       div_q;
    wfa_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .sum(div_sum),
        .wsum(nw_reg), .done(div_done), .result(div_q)
    );

    always_comb begin
        rd_addr   = addr_reg;
        wr_addr   = addr_reg;
        wr_acc    = 1'b0;
        wr_sh     = 1'b0;
        wd_sr     = nr_reg;
        wd_sg     = ng_reg;
        wd_sb     = nb_reg;
        wd_w      = nw_reg;
        wd_sh     = sh_reg;
        div_start = 1'b0;
        div_sum   = nr_reg;
        if (state_reg == ST_CLEAR) begin
            wr_addr = clr_reg;
            wr_acc  = 1'b1;
            wr_sh   = 1'b1;
            wd_sr   = '0;
            wd_sg   = '0;
            wd_sb   = '0;
            wd_w    = '0;
            wd_sh   = '0;
        end
        if (state_reg == ST_IDLE) begin
            rd_addr = AB'(s_lin);
        end
        unique case (state_reg)
            ST_DIV_G: div_sum = ng_reg;
            ST_DIV_B: div_sum = nb_reg;
            default:  div_sum = nr_reg;
        endcase
        if (state_reg == ST_UPD) begin
            wr_acc = 1'b1;
            wd_sr  = sat48(q_sr_reg, pr_reg);
            wd_sg  = sat48(q_sg_reg, pg_reg);
            wd_sb  = sat48(q_sb_reg, pb_reg);
            wd_w   = wsat;
        end
        if ((state_reg == ST_DIV_R || state_reg == ST_DIV_G || state_reg == ST_DIV_B)
            && !pend_reg) begin
            div_start = 1'b1;
        end
        // skipped pixels hold a stale address and colour, so only in-area ones write
        if (state_reg == ST_WAIT && cur_in) begin
            wr_sh = 1'b1;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == 8'(wfa_pkg::REG_WIDTH)) width_reg <= cfg_data;
                if (cfg_index == 8'(wfa_pkg::REG_HEIGHT)) height_reg <= cfg_data;
            end
            // a result loaded in ST_RD_OUT takes the place of the one draining
            if (out_valid_reg && m_ready && state_reg != ST_RD_OUT) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg <= s_data;
                        addr_reg <= AB'(s_lin);
                        oor_reg  <= !s_in;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        size_reg <= (s_data.splat_size > 4'(wfa_pkg::MaxSplat)) ?
                                    4'(wfa_pkg::MaxSplat) : s_data.splat_size;
                        state_reg <= (s_data.command == wfa_pkg::CMD_READ) ?
                                     ST_RD_WAIT : ST_PIX;
                    end
                end
                ST_RD_WAIT: state_reg <= ST_RD_OUT;
                ST_RD_OUT: begin
                    if (!out_valid_reg || m_ready) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= oor_reg ?
                                   wfa_pkg::out_item_t'{16'd0, 16'd0, 16'd0, 1'b1} :
                                   wfa_pkg::out_item_t'{q_sh_reg[47:32], q_sh_reg[31:16],
                                                        q_sh_reg[15:0], 1'b0};
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PIX: begin
                    if (j_reg >= size_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (cur_in) begin
                        addr_reg  <= AB'(cur_lin);
                        state_reg <= ST_LOAD;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_LOAD: begin
                    pr_reg <= SB'(mul_r);
                    pg_reg <= SB'(mul_g);
                    pb_reg <= SB'(mul_b);
                    state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_UPD;
                ST_UPD: begin
                    nr_reg <= sat48(q_sr_reg, pr_reg);
                    ng_reg <= sat48(q_sg_reg, pg_reg);
                    nb_reg <= sat48(q_sb_reg, pb_reg);
                    nw_reg <= wsat;
                    sh_reg <= q_sh_reg;
                    state_reg <= (wsat > 0) ? ST_DIV_R : ST_WAIT;
                end
                ST_DIV_R, ST_DIV_G, ST_DIV_B: begin
                    if (!pend_reg) begin
                        pend_reg <= 1'b1;
                    end else if (div_done) begin
                        pend_reg <= 1'b0;
                        unique case (state_reg)
                            ST_DIV_R: begin
                                sh_reg[47:32] <= div_q;
                                state_reg <= ST_DIV_G;
                            end
                            ST_DIV_G: begin
                                sh_reg[31:16] <= div_q;
                                state_reg <= ST_DIV_B;
                            end
                            default: begin
                                sh_reg[15:0] <= div_q;
                                state_reg <= ST_WAIT;
                            end
                        endcase
                    end
                end
                ST_WAIT: begin
                    // shown colors of an in-area pixel are written back now
                    if (i_reg + 1'b1 >= size_reg) begin
                        i_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                    state_reg <= ST_PIX;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, s_valid && s_ready, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_read_result, aclk, aresetn, state_reg == ST_RD_WAIT, state_reg == ST_RD_OUT)
    `ASSERT_IMPL(a_clear_no_out, aclk, aresetn, state_reg == ST_CLEAR, !m_valid)

endmodule

// ===== hw/rtl/wfa_divider.sv =====
// Restoring divider, one quotient bit per cycle, with 16-bit clamp.
// Depends on wfa_pkg.
module wfa_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [wfa_pkg::SumBits-1:0]  sum,
    input  logic signed [wfa_pkg::WsumBits-1:0] wsum,
    output logic                             done,
    output logic [15:0]                      result
);
    // dividend is sum*16 (52 bits); quotient above 17 bits always clamps
    localparam int DvdBits = wfa_pkg::SumBits + 4;
    localparam int CntBits = $clog2(DvdBits + 1);

    logic [DvdBits-1:0]         dvd_reg, dvd_next;
    logic [wfa_pkg::WsumBits:0] rem_reg, rem_next;
    logic [wfa_pkg::WsumBits-1:0] dsr_reg;
    logic [CntBits-1:0]         cnt_reg;
    logic                       busy_reg, zero_reg, big_reg, big_next, done_reg;
    logic [wfa_pkg::WsumBits:0] trial;
    logic [wfa_pkg::QuotBits-1:0] q_low;

    always_comb begin
        trial    = {rem_reg[wfa_pkg::WsumBits-1:0], dvd_reg[DvdBits-1]};
        dvd_next = {dvd_reg[DvdBits-2:0], 1'b0};
        rem_next = trial;
        big_next = big_reg;
        if (trial >= {1'b0, dsr_reg}) begin
            rem_next    = trial - {1'b0, dsr_reg};
            dvd_next[0] = 1'b1;
            if (cnt_reg > CntBits'(wfa_pkg::QuotBits)) begin
                big_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntBits'(DvdBits);
                dvd_reg  <= {sum[wfa_pkg::SumBits-1:0], 4'b0};
                rem_reg  <= '0;
                dsr_reg  <= wsum;
                zero_reg <= (sum <= 0);
                big_reg  <= 1'b0;
            end else if (busy_reg) begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                big_reg <= big_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntBits'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign q_low  = dvd_reg[wfa_pkg::QuotBits-1:0];
    assign result = zero_reg ? 16'd0 :
                    (big_reg || q_low[16]) ? 16'hFFFF : q_low[15:0];
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for weighted_film_accumulator: splat and read beats, film size changes.
// Depends on wfa_pkg and the weighted_film_accumulator RTL; needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        HalfPeriod = 4;
    localparam int        StallLimit = 300000;  // clearing pass plus the biggest splat, many times
    localparam int        DrainWait  = 12000;   // one oversized splat, clamped to 8x8 pixels
    localparam int        IdlePct    = 33;
    localparam logic [7:0] REG_SPARE = 8'd7;    // no register here, writes are dropped
    localparam longint    SumMax     = 64'sh7FFF_FFFF_FFFF;
    localparam longint    SumMin     = -SumMax - 1;
    localparam longint    WsumMax    = 64'sh7FFF_FFFF;
    localparam longint    WsumMin    = -WsumMax - 1;

    logic       aclk;
    logic       aresetn;
    logic       s_valid, s_ready;
    wfa_pkg::in_item_t  s_data;
    logic       m_valid, m_ready;
    wfa_pkg::out_item_t m_data;
    logic       cfg_valid, cfg_ready;
    logic [7:0] cfg_index;
    logic [8:0] cfg_data;

    weighted_film_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow film
    logic [8:0] film_w_reg, film_h_reg;
    longint     acc_r[wfa_pkg::Pixels], acc_g[wfa_pkg::Pixels], acc_b[wfa_pkg::Pixels];
    int         acc_wt[wfa_pkg::Pixels];
    bit [15:0]  disp_r[wfa_pkg::Pixels], disp_g[wfa_pkg::Pixels], disp_b[wfa_pkg::Pixels];

    wfa_pkg::in_item_t  pending_beats[$];
    wfa_pkg::out_item_t expected_pixels[$];
    int         mismatches;
    bit         sender_steady, receiver_steady;
    int         hold_off_left;
    bit         hold_off_done;
    int         pixels_seen;

    initial begin
        aclk = 1'b0;
        film_w_reg = 9'd256;
        film_h_reg = 9'd256;
    end
    always begin
        #HalfPeriod aclk = 1'b1;
        #HalfPeriod aclk = 1'b0;
    end

    function automatic bit [15:0] shade(longint sum, int wsum);
        longint q;
        if (sum <= 0) return 16'd0;
        q = (sum * 16) / longint'(wsum);
        return (q > 65535) ? 16'hFFFF : 16'(q);
    endfunction

    function automatic longint clip_sum(longint v);
        if (v > SumMax) return SumMax;
        if (v < SumMin) return SumMin;
        return v;
    endfunction

    // Update the shadow film with one accepted beat, queue any read result.
    function automatic void film_apply(wfa_pkg::in_item_t it);
        int w, h, size, x, y, a;
        longint wt, nw;
        wfa_pkg::out_item_t px;
        w = (film_w_reg > wfa_pkg::MaxWidth) ? wfa_pkg::MaxWidth : int'(film_w_reg);
        h = (film_h_reg > wfa_pkg::MaxHeight) ? wfa_pkg::MaxHeight : int'(film_h_reg);
        if (it.command == wfa_pkg::CMD_READ) begin
            px = '0;
            if (int'(it.pos_x) < w && int'(it.pos_y) < h) begin
                a = (int'(it.pos_y) * w + int'(it.pos_x)) % wfa_pkg::Pixels;
                px.pixel_red   = disp_r[a];
                px.pixel_green = disp_g[a];
                px.pixel_blue  = disp_b[a];
            end else begin
                px.out_of_range = 1'b1;
            end
            expected_pixels.push_back(px);
            return;
        end
        size = (it.splat_size > wfa_pkg::MaxSplat) ? wfa_pkg::MaxSplat : int'(it.splat_size);
        wt = longint'($signed(it.sample_weight));
        for (int j = 0; j < size; j++) begin
            for (int i = 0; i < size; i++) begin
                x = int'(it.pos_x) + i;
                y = int'(it.pos_y) + j;
                if (x >= w || y >= h) continue;
                a = (y * w + x) % wfa_pkg::Pixels;
                acc_r[a] = clip_sum(acc_r[a] + longint'(it.color_red) * wt);
                acc_g[a] = clip_sum(acc_g[a] + longint'(it.color_green) * wt);
                acc_b[a] = clip_sum(acc_b[a] + longint'(it.color_blue) * wt);
                nw = longint'(acc_wt[a]) + wt;
                if (nw > WsumMax) nw = WsumMax;
                if (nw < WsumMin) nw = WsumMin;
                acc_wt[a] = int'(nw);
                // non-positive weight sum leaves the display color alone
                if (nw > 0) begin
                    disp_r[a] = shade(acc_r[a], acc_wt[a]);
                    disp_g[a] = shade(acc_g[a], acc_wt[a]);
                    disp_b[a] = shade(acc_b[a], acc_wt[a]);
                end
            end
        end
    endfunction

    // Sender: hold each beat until taken, idle at random unless steady.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready)
                film_apply(s_data);
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 &&
                        (sender_steady || $urandom_range(99) >= IdlePct)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_beats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off to fill the block up.
    always @(posedge aclk) begin : receiver
        int errs;
        wfa_pkg::out_item_t exp_px;
        errs = 0;
        if (!aresetn) begin
            m_ready       <= 1'b0;
            hold_off_left <= 0;
            hold_off_done <= 1'b0;
            pixels_seen   <= 0;
            mismatches    <= 0;
        end else begin
            if (m_valid && m_ready) begin
                pixels_seen <= pixels_seen + 1;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result beat %p", m_data);
                    errs = errs + 1;
                end else begin
                    exp_px = expected_pixels.pop_front();
                    if (m_data.pixel_red !== exp_px.pixel_red) begin
                        $error("pixel_red expected %0d got %0d",
                               exp_px.pixel_red, m_data.pixel_red);
                        errs = errs + 1;
                    end
                    if (m_data.pixel_green !== exp_px.pixel_green) begin
                        $error("pixel_green expected %0d got %0d",
                               exp_px.pixel_green, m_data.pixel_green);
                        errs = errs + 1;
                    end
                    if (m_data.pixel_blue !== exp_px.pixel_blue) begin
                        $error("pixel_blue expected %0d got %0d",
                               exp_px.pixel_blue, m_data.pixel_blue);
                        errs = errs + 1;
                    end
                    if (m_data.out_of_range !== exp_px.out_of_range) begin
                        $error("out_of_range expected %0d got %0d",
                               exp_px.out_of_range, m_data.out_of_range);
                        errs = errs + 1;
                    end
                end
            end
            mismatches <= mismatches + errs;
            if (hold_off_left > 0) begin
                m_ready       <= 1'b0;
                hold_off_left <= hold_off_left - 1;
            end else if (!hold_off_done && pixels_seen == 60) begin
                m_ready       <= 1'b0;
                hold_off_left <= 6000;
                hold_off_done <= 1'b1;
            end else begin
                m_ready <= receiver_steady || ($urandom_range(99) >= IdlePct);
            end
        end
    end

    // Watchdog: cycles in which no channel moves a beat.
    int quiet_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
                (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic wfa_pkg::in_item_t beat(logic cmd, int x, int y, int size,
                                               int r, int g, int b, int wt);
        wfa_pkg::in_item_t it;
        it.command       = cmd;
        it.pos_x         = 8'(x);
        it.pos_y         = 8'(y);
        it.splat_size    = 4'(size);
        it.color_red     = 16'(r);
        it.color_green   = 16'(g);
        it.color_blue    = 16'(b);
        it.sample_weight = 16'(wt);
        return it;
    endfunction

    function automatic int pick_color();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(8191);
            default: return $urandom_range(65535);
        endcase
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(19))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3, 4, 5: return -int'($urandom_range(32767));
            6: return int'($urandom_range(65535)) - 32768;
            default: return 1 + $urandom_range(8191);
        endcase
    endfunction

    // Random beat: mostly small splats and reads on a hot corner so pixels
    // stack up many samples; some full-range and edge-straddling positions.
    function automatic wfa_pkg::in_item_t random_beat();
        int x, y, size, pick, w, h;
        w = (film_w_reg > wfa_pkg::MaxWidth) ? wfa_pkg::MaxWidth : int'(film_w_reg);
        h = (film_h_reg > wfa_pkg::MaxHeight) ? wfa_pkg::MaxHeight : int'(film_h_reg);
        pick = $urandom_range(9);
        if (pick < 7) begin
            x = $urandom_range(12);
            y = $urandom_range(12);
        end else if (pick < 9) begin
            x = $urandom_range(255);
            y = $urandom_range(255);
        end else begin
            x = w - 4 + $urandom_range(7);
            y = h - 4 + $urandom_range(7);
            if (x < 0) x = 0;
            if (y < 0) y = 0;
            if (x > 255) x = 255;
            if (y > 255) y = 255;
        end
        pick = $urandom_range(99);
        if (pick < 8)       size = 0;
        else if (pick < 65) size = 1;
        else if (pick < 92) size = 2 + $urandom_range(1);
        else if (pick < 98) size = 4 + $urandom_range(3);
        else                size = 8 + $urandom_range(7);
        return beat(($urandom_range(99) < 40) ? wfa_pkg::CMD_READ : wfa_pkg::CMD_ACCUM,
                    x, y, size, pick_color(), pick_color(), pick_color(), pick_weight());
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_pixels.size() != 0);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [8:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == 8'(wfa_pkg::REG_WIDTH))
            film_w_reg = value;
        else if (idx == 8'(wfa_pkg::REG_HEIGHT))
            film_h_reg = value;
    endtask

    // Resize the film once the block has gone quiet; an accumulate leaves no
    // result behind, so give its last splat time to finish first.
    task automatic resize(int w, int h);
        wait_drained();
        repeat (DrainWait) @(posedge aclk);
        write_reg(8'(wfa_pkg::REG_WIDTH), 9'(w));
        write_reg(8'(wfa_pkg::REG_HEIGHT), 9'(h));
    endtask

    task automatic run_random(int n);
        repeat (n) pending_beats.push_back(random_beat());
        wait_drained();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full 256x256 film straight out of reset
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        // corner splat hangs off both edges, one pixel lands
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 255, 255, 8,
                                     65535, 65535, 65535, 4096));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 255, 255, 0, 0, 0, 0, 0));
        // size zero writes nothing
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 0, 0, 0, 4096, 4096, 4096, 4096));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        // oversized splat clamps to 8x8
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 0, 0, 15, 4096, 2048, 1024, 4096));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 7, 7, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 8, 8, 0, 0, 0, 0, 0));
        // negative weight sum keeps the old display color
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 1, 1, 1, 65535, 100, 0, -32768));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 1, 1, 0, 0, 0, 0, 0));
        // weight sum back above zero with a negative red sum: red display goes to 0
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 1, 1, 1, 100, 100, 100, 32767));
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 1, 1, 1, 100, 100, 100, 32767));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 1, 1, 0, 0, 0, 0, 0));
        // bright color, quotient clamps to full scale
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 30, 30, 1, 65535, 8192, 0, 1));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 30, 30, 0, 0, 0, 0, 0));
        // zero weight on a fresh pixel: weight sum stays zero
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 40, 40, 2, 65535, 65535, 65535, 0));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 41, 41, 0, 0, 0, 0, 0));
        wait_drained();

        // long stretch with no idling on either side
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        run_random(250);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        resize(1, 1);
        write_reg(REG_SPARE, 9'h1FF);
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 1, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 0, 1, 0, 0, 0, 0, 0));
        run_random(60);

        resize(0, 5);   // empty film
        pending_beats.push_back(beat(wfa_pkg::CMD_ACCUM, 0, 0, 2, 4096, 4096, 4096, 4096));
        pending_beats.push_back(beat(wfa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        run_random(30);

        resize(511, 511);   // saturates to the full film
        run_random(400);

        resize(17, 9);
        run_random(300);

        resize(256, 256);
        run_random(110);

        wait_drained();
        repeat (DrainWait) @(posedge aclk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
